>>> hw/rtl/pulse_period_estimator_macros.svh
// assertion macros shared by the pulse period estimator modules
`ifndef PULSE_PERIOD_ESTIMATOR_MACROS_SVH
`define PULSE_PERIOD_ESTIMATOR_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ppe_pkg.sv
// types and constants of the pulse period estimator
package ppe_pkg;

  localparam int unsigned WIDTH_W  = 16;  // input width field
  localparam int unsigned PERIOD_W = 12;  // result period field
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned COUNT_W  = 16;  // histogram bin width

  typedef enum logic [2:0] {
    S_CLEAR,  // clearing pass after reset
    S_IDLE,   // waiting for a width
    S_ADD,    // kernel read-modify-write sweep
    S_CHECK,  // last write-back, decide on peak search
    S_SCAN,   // peak search, clearing each bin as it is read
    S_DONE    // hand the result to the output register
  } ppe_state_e;

  typedef struct packed {
    logic load;     // capture the input transfer
    logic add_rd;   // read one kernel bin, advance kernel offset
    logic clr_wr;   // write zero at sweep index, advance
    logic scan_rd;  // read and clear at sweep index, advance
    logic emit;     // load the result register, end the run
  } ppe_cmd_t;

  typedef struct packed {
    logic in_range;  // captured width lands in the histogram
    logic last;      // captured width closes the run
    logic k_end;     // kernel offset at its final value
    logic idx_end;   // sweep index at the top bin
    logic out_busy;  // result register holds an untaken result
    logic seen;      // a width reached the histogram in this run
    logic wb_vld;    // kernel write-back in flight
    logic scan_vld;  // peak compare in flight
  } ppe_sts_t;

endpackage

>>> hw/rtl/ppe_ram.sv
// generic single-write, single-read RAM with registered read data
module ppe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents when both ports hit one address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ppe_datapath.sv
// histogram datapath: kernel add, clearing sweep, peak search, result register
module ppe_datapath #(
  parameter int unsigned HIST_BINS = 4096,
  parameter int unsigned TRI       = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ppe_pkg::ppe_cmd_t                cmd_i,
  output ppe_pkg::ppe_sts_t                sts_o,
  input  logic [ppe_pkg::WIDTH_W-1:0]      width_i,
  input  logic                             last_i,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic [ppe_pkg::PERIOD_W-1:0]     period_o,
  output logic                             empty_o
);

  localparam int unsigned AW   = $clog2(HIST_BINS);
  localparam int unsigned NK   = 2 * TRI - 1;
  localparam int unsigned KW   = $clog2(NK);
  localparam int unsigned KW1  = KW + 1;
  localparam int unsigned WW   = $clog2(TRI + 1);
  localparam int unsigned CW   = ppe_pkg::COUNT_W;
  localparam int unsigned SW   = ppe_pkg::WIDTH_W + 2;
  localparam int unsigned HALF = TRI - 1;

  logic [ppe_pkg::WIDTH_W-1:0] w_q;
  logic                        last_q;
  logic [KW-1:0]               k_q;
  logic [AW-1:0]               idx_q, scan_idx_q;
  logic                        seen_q, wb_vld_q, scan_vld_q;
  logic [AW-1:0]               wb_addr_q;
  logic [WW-1:0]               wt_q;
  logic [CW-1:0]               best_val_q;
  logic [AW-1:0]               best_idx_q;
  logic                        m_valid_q;
  logic [ppe_pkg::PERIOD_W-1:0] period_q;
  logic                        empty_q;

  logic signed [SW-1:0] add_addr;
  logic                 add_ok;
  logic [KW1-1:0]       k_dist;
  logic [WW-1:0]        wt;
  logic [CW-1:0]        rdata;
  logic [CW:0]          sum;
  logic [CW-1:0]        sat;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [CW-1:0]        wdata;
  logic                 idx_end;

  // kernel bin for the current offset: width - (TRI-1) + k
  always_comb begin
    add_addr = $signed({2'b00, w_q}) - $signed(SW'(HALF))
             + $signed({{(SW - KW){1'b0}}, k_q});
    add_ok   = !add_addr[SW-1] && (add_addr < $signed(SW'(HIST_BINS)));
    if ({1'b0, k_q} >= KW1'(HALF)) begin
      k_dist = {1'b0, k_q} - KW1'(HALF);
    end else begin
      k_dist = KW1'(HALF) - {1'b0, k_q};
    end
    wt = WW'(TRI) - WW'(k_dist);
  end

  // saturating add on the write-back stage
  always_comb begin
    sum = {1'b0, rdata} + (CW + 1)'(wt_q);
    sat = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
  end

  assign idx_end = (idx_q == AW'(HIST_BINS - 1));

  // one write port: clearing sweep, clear-on-read scan or kernel write-back
  always_comb begin
    we    = cmd_i.clr_wr | cmd_i.scan_rd | wb_vld_q;
    waddr = wb_vld_q ? wb_addr_q : idx_q;
    wdata = wb_vld_q ? sat : '0;
    raddr = cmd_i.add_rd ? add_addr[AW-1:0] : idx_q;
  end

  ppe_ram #(
    .WIDTH (CW),
    .DEPTH (HIST_BINS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q    <= width_i;
      last_q <= last_i;
    end
    if (cmd_i.add_rd) begin
      wb_addr_q <= add_addr[AW-1:0];
      wt_q      <= wt;
    end
    if (cmd_i.scan_rd) begin
      scan_idx_q <= idx_q;
    end
    if (cmd_i.emit) begin
      period_q <= seen_q ? ppe_pkg::PERIOD_W'(best_idx_q) : '0;
      empty_q  <= !seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      idx_q      <= '0;
      seen_q     <= 1'b0;
      wb_vld_q   <= 1'b0;
      scan_vld_q <= 1'b0;
      best_val_q <= '0;
      best_idx_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      wb_vld_q   <= cmd_i.add_rd & add_ok;
      scan_vld_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        k_q <= '0;
      end else if (cmd_i.add_rd) begin
        k_q <= k_q + KW'(1);
      end
      if (cmd_i.clr_wr || cmd_i.scan_rd) begin
        idx_q <= idx_end ? '0 : idx_q + AW'(1);
      end
      // strict compare keeps the lowest index on ties
      if (scan_vld_q && (rdata > best_val_q)) begin
        best_val_q <= rdata;
        best_idx_q <= scan_idx_q;
      end
      if (cmd_i.emit) begin
        seen_q     <= 1'b0;
        best_val_q <= '0;
        best_idx_q <= '0;
      end else if (cmd_i.add_rd) begin
        seen_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.in_range = ({1'b0, w_q} < (ppe_pkg::WIDTH_W + 1)'(HIST_BINS));
    sts_o.last     = last_q;
    sts_o.k_end    = (k_q == KW'(NK - 1));
    sts_o.idx_end  = idx_end;
    sts_o.out_busy = m_valid_q & ~m_ready_i;
    sts_o.seen     = seen_q;
    sts_o.wb_vld   = wb_vld_q;
    sts_o.scan_vld = scan_vld_q;
  end

  assign m_valid_o = m_valid_q;
  assign period_o  = period_q;
  assign empty_o   = empty_q;

endmodule

>>> hw/rtl/ppe_ctrl.sv
// controller state machine of the pulse period estimator
`include "pulse_period_estimator_macros.svh"

module ppe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  ppe_pkg::ppe_sts_t sts_i,
  output ppe_pkg::ppe_cmd_t cmd_o
);

  ppe_pkg::ppe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppe_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppe_pkg::S_CLEAR: begin
        if (sts_i.idx_end) state_d = ppe_pkg::S_IDLE;
      end
      ppe_pkg::S_IDLE: begin
        if (s_valid_i) state_d = ppe_pkg::S_ADD;
      end
      ppe_pkg::S_ADD: begin
        if (!sts_i.in_range || sts_i.k_end) state_d = ppe_pkg::S_CHECK;
      end
      ppe_pkg::S_CHECK: begin
        if (!sts_i.last) begin
          state_d = ppe_pkg::S_IDLE;
        end else if (sts_i.seen) begin
          state_d = ppe_pkg::S_SCAN;
        end else begin
          state_d = ppe_pkg::S_DONE;
        end
      end
      ppe_pkg::S_SCAN: begin
        if (sts_i.idx_end) state_d = ppe_pkg::S_DONE;
      end
      ppe_pkg::S_DONE: begin
        if (!sts_i.out_busy && !sts_i.scan_vld) state_d = ppe_pkg::S_IDLE;
      end
      default: state_d = ppe_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ppe_pkg::S_CLEAR: cmd_o.clr_wr = 1'b1;
      ppe_pkg::S_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ppe_pkg::S_ADD:  cmd_o.add_rd = sts_i.in_range;
      ppe_pkg::S_CHECK: ;
      ppe_pkg::S_SCAN: cmd_o.scan_rd = 1'b1;
      ppe_pkg::S_DONE: cmd_o.emit = !sts_i.out_busy && !sts_i.scan_vld;
      default: ;
    endcase
  end

  `PPE_ASSERT_NEXT(a_accept_starts_add, clk_i, rst_ni, s_valid_i && s_ready_o,
      state_q == ppe_pkg::S_ADD, "accepted width did not start kernel sweep")
  `PPE_ASSERT_NOW(a_one_writer, clk_i, rst_ni, 1'b1,
      $onehot0({cmd_o.clr_wr, cmd_o.scan_rd, sts_i.wb_vld}),
      "histogram write port driven by two sources")
  `PPE_ASSERT_NOW(a_emit_free, clk_i, rst_ni, cmd_o.emit,
      !sts_i.out_busy && !sts_i.scan_vld,
      "result emitted over pending result or open compare")
  `PPE_ASSERT_NOW(a_add_in_range, clk_i, rst_ni, cmd_o.add_rd, sts_i.in_range,
      "kernel sweep for a width beyond the histogram")

endmodule

>>> hw/rtl/pulse_period_estimator.sv
// top level of the pulse period estimator
//
// channel  | dir | tdata                       | tuser      | tlast
// ---------+-----+-----------------------------+------------+-----------
// s_axis   | in  | [15:0] width (us)           | -          | last width
// m_axis   | out | [11:0] period, [15:12] zero | empty_res  | -
//
// a width is accepted, then each kernel bin is read and written back on the single
// histogram write port with read and write-back overlapped, then the width is checked
// a width beyond the histogram skips the kernel sweep; a width marked last in a run
// that reached the histogram adds a peak search that clears every bin
// after reset a clearing pass over all HIST_BINS bins runs before s_axis_tready rises
// new widths are taken while a result waits, until the next result stalls behind it
module pulse_period_estimator #(
  parameter int unsigned HIST_BINS = 4096,  // histogram depth, 256..4096
  parameter int unsigned TRI       = 10     // kernel peak weight, 2..32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input widths
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] width
  input  logic        s_axis_tlast,   // last width of the run
  // estimated period
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] period, [15:12] zero
  output logic        m_axis_tuser    // [0] empty_res
);

  ppe_pkg::ppe_cmd_t             cmd;
  ppe_pkg::ppe_sts_t             sts;
  logic [ppe_pkg::PERIOD_W-1:0]  period;

  // sequencing of accept, kernel sweep, peak search and result handoff
  ppe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // histogram memory, kernel arithmetic, peak tracking and result register
  ppe_datapath #(
    .HIST_BINS (HIST_BINS),
    .TRI       (TRI)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .width_i   (s_axis_tdata[ppe_pkg::WIDTH_W-1:0]),
    .last_i    (s_axis_tlast),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .period_o  (period),
    .empty_o   (m_axis_tuser)
  );

  // period padded with zeros to whole bytes
  assign m_axis_tdata = {{(ppe_pkg::OUT_TDATA_W - ppe_pkg::PERIOD_W){1'b0}}, period};

endmodule
